// ----- hdl/owtd_pkg.sv -----
// Shared types, constants and the CRC8 step for the 1-Wire scratchpad temperature decoder.
`default_nettype none
package owtd_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int FRAME_BYTES = 9;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 4;
  localparam int TEMP_W      = 18;
  localparam int STATUS_W    = 2;
  localparam int TDATA_W     = ((TEMP_W + 7) / 8) * 8;
  localparam int NUM_W       = BYTE_W + FRAC_BITS;
  localparam int CNT_W       = $clog2(NUM_W);
  localparam int SUM_W       = (NUM_W + 3 > TEMP_W) ? NUM_W + 3 : TEMP_W;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
  localparam logic [POS_W-1:0]  LAST_POS = POS_W'(FRAME_BYTES - 1);

  localparam logic [POS_W-1:0] POS_TEMP_LSB = 4'd0;
  localparam logic [POS_W-1:0] POS_TEMP_MSB = 4'd1;
  localparam logic [POS_W-1:0] POS_CNT_REM  = 4'd6;
  localparam logic [POS_W-1:0] POS_CNT_PER  = 4'd7;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_ZERO_CNT = 2'd2
  } status_t;

  typedef struct packed {
    logic take;
    logic div_start;
    logic div_step;
    logic out_load;
  } owtd_cmd_t;

  typedef struct packed {
    logic last_byte;
    logic frame_ok;
    logic div_done;
  } owtd_sts_t;

  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc_in,
                                                     input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/onewire_scratchpad_temperature_decode.sv -----
// Top level of the 1-Wire scratchpad temperature decoder.
// Takes the nine scratchpad bytes of a 1-Wire thermometer, one beat per byte, with
// s_tuser marking byte 0 of a frame (a mid-frame start restarts the frame; after the
// ninth byte the next byte starts a frame on its own). Bytes 0 to 7 are taken one per
// cycle. The ninth byte yields one result beat: temperature in 1/256 degree Celsius
// and a status (ok, CRC error, zero count per degree; temperature is 0 unless ok).
// A good frame runs the bit-serial divider for the count fraction (state S_DIV) and
// then loads the result register (state S_DONE), so after the ninth byte s_tready
// stays low through both states; a bad frame skips the divider and keeps it low only
// while the result is loaded. Either waits longer while an earlier result is still
// unaccepted at the output. A result waiting at the output does not block bytes 0-7.
`default_nettype none
module onewire_scratchpad_temperature_decode (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [owtd_pkg::BYTE_W-1:0]         s_tdata,  // [7:0] data_byte
  input  wire                                 s_tuser,  // [0] frame_start
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [owtd_pkg::TDATA_W-1:0]        m_tdata,  // [17:0] temperature, rest zero
  output logic [owtd_pkg::STATUS_W-1:0]       m_tuser   // [1:0] status
);

  owtd_pkg::owtd_cmd_t              cmd;
  owtd_pkg::owtd_sts_t              sts;
  logic signed [owtd_pkg::TEMP_W-1:0] temperature;
  owtd_pkg::status_t                status;

  owtd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  owtd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (s_tdata),
    .frame_start (s_tuser),
    .cmd         (cmd),
    .sts         (sts),
    .temperature (temperature),
    .status      (status)
  );

  assign m_tdata = {{(owtd_pkg::TDATA_W - owtd_pkg::TEMP_W){1'b0}}, temperature};
  assign m_tuser = status;

endmodule
`default_nettype wire

// ----- hdl/owtd_ctrl.sv -----
// Control state machine: byte intake, division sequencing and output handoff.
`default_nettype none
module owtd_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire                 m_tready,
  input  owtd_pkg::owtd_sts_t sts,
  output owtd_pkg::owtd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;
  logic   m_tvalid_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.take      = s_tvalid && s_tready;
    unique case (state)
      S_IDLE: begin
        if (cmd.take && sts.last_byte) begin
          if (sts.frame_ok) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.out_load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending beat");

  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("output beat raised outside result handoff");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && sts.div_done) |=> state == S_DONE)
    else $error("division end not followed by handoff");

endmodule
`default_nettype wire

// ----- hdl/owtd_dp.sv -----
// Datapath: CRC8, scratchpad field capture, iterative divider and temperature sum.
`default_nettype none
module owtd_dp (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire  [owtd_pkg::BYTE_W-1:0]          data_byte,
  input  wire                                  frame_start,
  input  owtd_pkg::owtd_cmd_t                  cmd,
  output owtd_pkg::owtd_sts_t                  sts,
  output logic signed [owtd_pkg::TEMP_W-1:0]   temperature,
  output owtd_pkg::status_t                    status
);

  localparam logic [owtd_pkg::SUM_W-1:0] QUARTER =
    owtd_pkg::SUM_W'(1) << (owtd_pkg::FRAC_BITS - 2);

  logic [owtd_pkg::POS_W-1:0]  pos;
  logic [owtd_pkg::BYTE_W-1:0] crc;
  logic [owtd_pkg::BYTE_W-1:0] temp_lsb;
  logic                        temp_sign;
  logic [owtd_pkg::BYTE_W-1:0] cnt_rem;
  logic [owtd_pkg::BYTE_W-1:0] cnt_per;
  owtd_pkg::status_t           frame_status;

  logic [owtd_pkg::BYTE_W-1:0] rem;
  logic [owtd_pkg::NUM_W-1:0]  num;
  logic                        neg;
  logic [owtd_pkg::CNT_W-1:0]  step_cnt;

  logic [owtd_pkg::POS_W-1:0]  pos_eff;
  logic [owtd_pkg::BYTE_W-1:0] crc_base;
  logic [owtd_pkg::BYTE_W-1:0] crc_new;

  logic signed [owtd_pkg::BYTE_W:0]   diff;
  logic [owtd_pkg::BYTE_W-1:0]        diff_mag;
  logic [owtd_pkg::BYTE_W:0]          rem_shift;
  logic                               q_bit;
  logic [owtd_pkg::BYTE_W:0]          rem_sub;

  logic [owtd_pkg::BYTE_W:0]          t9_adj;
  logic [owtd_pkg::BYTE_W-1:0]        half;
  logic [owtd_pkg::SUM_W-1:0]         whole;
  logic [owtd_pkg::SUM_W-1:0]         q_ext;
  logic [owtd_pkg::SUM_W-1:0]         frac;
  logic [owtd_pkg::SUM_W-1:0]         sum;

  assign pos_eff  = frame_start ? '0 : pos;
  assign crc_base = frame_start ? '0 : crc;
  assign crc_new  = owtd_pkg::crc8_update(crc_base, data_byte);

  assign sts.last_byte = (pos_eff == owtd_pkg::LAST_POS);
  assign sts.frame_ok  = (crc_new == '0) && (cnt_per != '0);
  assign sts.div_done  = (step_cnt == owtd_pkg::CNT_W'(owtd_pkg::NUM_W - 1));

  assign diff     = $signed({1'b0, cnt_per}) - $signed({1'b0, cnt_rem});
  assign diff_mag = diff[owtd_pkg::BYTE_W] ? owtd_pkg::BYTE_W'(-diff) : diff[owtd_pkg::BYTE_W-1:0];

  assign rem_shift = {rem, num[owtd_pkg::NUM_W-1]};
  assign q_bit     = (rem_shift >= {1'b0, cnt_per});
  assign rem_sub   = rem_shift - {1'b0, cnt_per};

  // trunc(t9 / 2) toward zero
  assign t9_adj = {temp_sign, temp_lsb} + {{owtd_pkg::BYTE_W{1'b0}}, temp_sign};
  assign half   = t9_adj[owtd_pkg::BYTE_W:1];
  assign whole  = {{(owtd_pkg::SUM_W - owtd_pkg::BYTE_W){half[owtd_pkg::BYTE_W-1]}}, half}
                  << owtd_pkg::FRAC_BITS;
  assign q_ext  = {{(owtd_pkg::SUM_W - owtd_pkg::NUM_W){1'b0}}, num};
  assign frac   = neg ? -q_ext : q_ext;
  assign sum    = whole - QUARTER + frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= '0;
      crc          <= '0;
      temp_lsb     <= '0;
      temp_sign    <= 1'b0;
      cnt_rem      <= '0;
      cnt_per      <= '0;
      frame_status <= owtd_pkg::ST_OK;
    end else if (cmd.take) begin
      unique case (pos_eff)
        owtd_pkg::POS_TEMP_LSB: temp_lsb  <= data_byte;
        owtd_pkg::POS_TEMP_MSB: temp_sign <= data_byte[0];
        owtd_pkg::POS_CNT_REM:  cnt_rem   <= data_byte;
        owtd_pkg::POS_CNT_PER:  cnt_per   <= data_byte;
        default: ;
      endcase
      if (sts.last_byte) begin
        pos <= '0;
        crc <= '0;
        if (crc_new != '0) begin
          frame_status <= owtd_pkg::ST_CRC_ERR;
        end else if (cnt_per == '0) begin
          frame_status <= owtd_pkg::ST_ZERO_CNT;
        end else begin
          frame_status <= owtd_pkg::ST_OK;
        end
      end else begin
        pos <= pos_eff + owtd_pkg::POS_W'(1);
        crc <= crc_new;
      end
    end
  end

  // restoring divider, one quotient bit per cycle; num turns into the quotient
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem      <= '0;
      num      <= {diff_mag, {owtd_pkg::FRAC_BITS{1'b0}}};
      neg      <= diff[owtd_pkg::BYTE_W];
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      rem      <= q_bit ? rem_sub[owtd_pkg::BYTE_W-1:0] : rem_shift[owtd_pkg::BYTE_W-1:0];
      num      <= {num[owtd_pkg::NUM_W-2:0], q_bit};
      step_cnt <= step_cnt + owtd_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= frame_status;
      if (frame_status == owtd_pkg::ST_OK) begin
        temperature <= sum[owtd_pkg::TEMP_W-1:0];
      end else begin
        temperature <= '0;
      end
    end
  end

endmodule
`default_nettype wire
